// ===== hdl/itpi_pkg.sv =====
// Shared types and constants of the interval timer port interface.
package itpi_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int QUO_W = 21;
	localparam int DIV_W = 17;
	localparam int CNT_W = $clog2(QUO_W + 1);

	localparam logic [QUO_W-1:0] PIT_CLOCK_HZ = 21'd1193182;
	localparam logic [DIV_W-1:0] FULL_COUNT   = 17'h10000;
	localparam logic [15:0]      COUNT_STEP   = 16'd10;
	localparam logic [QUO_W-1:0] PERIOD_RESET = 21'd54925;

	localparam logic       CMD_READ    = 1'b0;
	localparam logic       CMD_WRITE   = 1'b1;
	localparam logic [1:0] PORT_MODE   = 2'd3;

	localparam logic [1:0] MODE_LATCH  = 2'd0;
	localparam logic [1:0] MODE_LOW    = 2'd1;
	localparam logic [1:0] MODE_HIGH   = 2'd2;
	localparam logic [1:0] MODE_TOGGLE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/itpi_div.sv =====
// Bit-serial restoring divider of the timer clock by a channel count.
module itpi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  itpi_pkg::div_req_t  req,
	output itpi_pkg::div_rsp_t  rsp
);

	logic                        active_q;
	logic                        done_q;
	logic [itpi_pkg::CNT_W-1:0]  cnt_q;
	logic [itpi_pkg::DIV_W-1:0]  div_q;
	logic [itpi_pkg::DIV_W-1:0]  rem_q;
	logic [itpi_pkg::QUO_W-1:0]  quo_q;

	logic [itpi_pkg::DIV_W:0]    shifted;
	logic [itpi_pkg::DIV_W:0]    diff;
	logic                        ge;

	// bring down the next dividend bit and trial-subtract
	always_comb begin
		shifted = {rem_q, quo_q[itpi_pkg::QUO_W-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= itpi_pkg::CNT_W'(itpi_pkg::QUO_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == itpi_pkg::CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= itpi_pkg::PIT_CLOCK_HZ;
		end else if (active_q) begin
			rem_q <= ge ? diff[itpi_pkg::DIV_W-1:0] : shifted[itpi_pkg::DIV_W-1:0];
			quo_q <= {quo_q[itpi_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hdl/interval_timer_port_interface.sv =====
// Top level of the interval timer port interface.
// A data write to channel 0 runs the divider and strobes done once it has
// finished; busy stays high until the cycle after done.
// Every other access strobes done in the cycle after acceptance.
// The 21-step bit-serial divider sets the rate of channel 0 data writes. The receiver cannot stall.
// Reset clears all channel state, speaker off, timer period 54925.
module interval_timer_port_interface (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [1:0]  port,
	input  logic [7:0]  write_data,
	input  logic        speaker_gate,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        speaker_enabled,
	output logic [20:0] tick_period
);

	localparam int NCH = itpi_pkg::NUM_CHANNELS;

	itpi_pkg::state_t state_q, state_d;

	logic [1:0]  mode_q   [NCH];
	logic        toggle_q [NCH];
	logic [15:0] reload_q [NCH];
	logic [15:0] count_q  [NCH];
	logic        speaker_q;
	logic [20:0] period_q;
	logic [7:0]  rdata_q;

	itpi_pkg::div_req_t div_req;
	itpi_pkg::div_rsp_t div_rsp;

	logic                      accept;
	logic                      data_port;
	logic                      mode_ok;
	logic [itpi_pkg::CH_W-1:0] ch;
	logic [itpi_pkg::CH_W-1:0] mch;
	logic [1:0]                mode;
	logic                      tog;
	logic                      wr_low;
	logic                      rd_low;
	logic [15:0]               new_reload;
	logic [15:0]               base_cnt;
	logic [15:0]               dec_cnt;
	logic                      launch;

	always_comb begin
		accept     = start && !busy;
		data_port  = 3'(port) < 3'(NCH);
		mode_ok    = 3'(write_data[7:6]) < 3'(NCH);
		ch         = port[itpi_pkg::CH_W-1:0];
		mch        = write_data[itpi_pkg::CH_W+5:6];
		mode       = mode_q[ch];
		tog        = toggle_q[ch];
		wr_low     = (mode == itpi_pkg::MODE_LOW) || (mode == itpi_pkg::MODE_TOGGLE && !tog);
		rd_low     = (mode == itpi_pkg::MODE_LATCH) || wr_low;
		new_reload = wr_low ? {reload_q[ch][15:8], write_data}
		                    : {write_data, reload_q[ch][7:0]};
		// reload first when the count has run below one step
		base_cnt   = (count_q[ch] < itpi_pkg::COUNT_STEP) ? reload_q[ch] : count_q[ch];
		dec_cnt    = base_cnt - itpi_pkg::COUNT_STEP;
		launch     = accept && command == itpi_pkg::CMD_WRITE && port != itpi_pkg::PORT_MODE
		             && data_port && ch == itpi_pkg::CH_W'(0);
	end

	always_comb begin
		div_req.start   = launch;
		div_req.divisor = (new_reload == 16'd0) ? itpi_pkg::FULL_COUNT : {1'b0, new_reload};
	end

	itpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itpi_pkg::ST_IDLE: begin
				if (accept) state_d = launch ? itpi_pkg::ST_DIV : itpi_pkg::ST_RESP;
			end
			itpi_pkg::ST_DIV: begin
				if (div_rsp.done) state_d = itpi_pkg::ST_RESP;
			end
			itpi_pkg::ST_RESP: state_d = itpi_pkg::ST_IDLE;
			default:           state_d = itpi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			itpi_pkg::ST_IDLE: busy = 1'b0;
			itpi_pkg::ST_DIV:  busy = 1'b1;
			itpi_pkg::ST_RESP: done = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= itpi_pkg::ST_IDLE;
			speaker_q <= 1'b0;
			period_q  <= itpi_pkg::PERIOD_RESET;
			for (int i = 0; i < NCH; i++) begin
				mode_q[i]   <= itpi_pkg::MODE_LATCH;
				toggle_q[i] <= 1'b0;
				reload_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == itpi_pkg::ST_DIV && div_rsp.done) begin
				period_q <= div_rsp.quotient;
			end
			if (accept) begin
				if (command == itpi_pkg::CMD_WRITE) begin
					if (port == itpi_pkg::PORT_MODE) begin
						// drop a mode write for an absent channel
						if (mode_ok) begin
							mode_q[mch] <= write_data[5:4];
							if (write_data[5:4] == itpi_pkg::MODE_TOGGLE) toggle_q[mch] <= 1'b0;
						end
					end else if (data_port) begin
						reload_q[ch] <= new_reload;
						speaker_q    <= (new_reload != 16'd0) && speaker_gate;
						if (mode == itpi_pkg::MODE_TOGGLE) toggle_q[ch] <= !tog;
					end
				end else if (port != itpi_pkg::PORT_MODE && data_port) begin
					if (mode == itpi_pkg::MODE_LATCH || mode == itpi_pkg::MODE_TOGGLE) begin
						toggle_q[ch] <= !tog;
					end
					if (rd_low) count_q[ch] <= dec_cnt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= 8'd0;
			if (command == itpi_pkg::CMD_READ && port != itpi_pkg::PORT_MODE && data_port) begin
				rdata_q <= rd_low ? dec_cnt[7:0] : count_q[ch][15:8];
			end
		end
	end

	assign read_data       = rdata_q;
	assign speaker_enabled = speaker_q;
	assign tick_period     = period_q;

endmodule
